[hdl/aes_cfb_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aes_cfb_pkg
// Shared types, operation codes and AES round functions for the CFB128 core.
// ---------------------------------------------------------------------------
package aes_cfb_pkg;

  localparam int AES_ROUNDS_DEF = 10;
  localparam int BLOCK_W        = 128;
  localparam int HALF_W         = 64;
  localparam int SLOT_W         = 5;
  localparam int OP_W           = 2;
  localparam int IN_DATA_W      = 200;
  localparam int OUT_DATA_W     = 128;
  localparam int CFG_ADDR_W     = 1;

  // operation codes (in_tuser)
  localparam logic [OP_W-1:0] OP_LOAD_KEY = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCRYPT  = 2'd1;
  localparam logic [OP_W-1:0] OP_DECRYPT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_IV_HIGH = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IV_LOW  = 1'd1;

  // controller -> datapath commands
  typedef struct packed {
    logic start;      // take the block, set up chain and work state
    logic decrypt;    // valid with start
    logic key_load;   // write one round key half
    logic key_rd;     // fetch a round key (data next cycle)
    logic init_add;   // initial AddRoundKey
    logic round_step; // one cipher round
    logic last_round; // round without MixColumns
    logic finish;     // produce result, update chain
  } aes_cmd_t;

  typedef struct packed {
    logic out_busy;   // output register holds a result that is not taken
  } aes_sts_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int i);
    return s[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes + ShiftRows, column-major byte order
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    return t;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c+1);
      a2  = get_byte(s, 4*c+2);
      a3  = get_byte(s, 4*c+3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c)   -: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
      t[BLOCK_W-1-8*(4*c+1) -: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
      t[BLOCK_W-1-8*(4*c+2) -: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      t[BLOCK_W-1-8*(4*c+3) -: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    return t;
  endfunction

endpackage : aes_cfb_pkg
`default_nettype wire

[hdl/aes128_cfb_cipher.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aes128_cfb_cipher
// AES-128 CFB128 encrypt/decrypt core with external round keys.
// ---------------------------------------------------------------------------
// One request at a time. A key load (operation 0) or an unused operation leaves
// the core ready for the next request. An encrypt or decrypt request runs from
// acceptance to the result in the output register: the accepting edge loads the
// chaining value, then the single shared round unit does the initial key add
// and ROUND_COUNT rounds, and a last step forms the result, which waits while an
// older result is not yet taken. The next request is accepted the cycle after
// that. Round keys must be loaded before use; IV writes take effect at the next
// request with restart set.
module aes128_cfb_cipher
  import aes_cfb_pkg::*;
#(
  parameter int ROUND_COUNT = AES_ROUNDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [4:0] key_slot, [68:5] key_word, [69] restart, [133:70] block_high,
  // [197:134] block_low, [199:198] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  wire logic [OP_W-1:0]       in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [63:0] result_high, [127:64] result_low
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [HALF_W-1:0]     cfg_wdata
);

  localparam int ROUND_W = $clog2(ROUND_COUNT + 1);

  aes_cmd_t           cmd;
  aes_sts_t           sts;
  logic [ROUND_W-1:0] key_rd_idx;

  aes_cfb_ctrl #(.ROUND_COUNT(ROUND_COUNT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .operation  (in_tuser),
    .sts        (sts),
    .cmd        (cmd),
    .key_rd_idx (key_rd_idx)
  );

  aes_cfb_dp #(.ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .key_rd_idx (key_rd_idx),
    .sts        (sts)
  );

endmodule : aes128_cfb_cipher
`default_nettype wire

[hdl/aes_cfb_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aes_cfb_ctrl
// Sequencer: accepts requests, steps the round counter, schedules key
// fetches and hands the result to the output register.
// ---------------------------------------------------------------------------
module aes_cfb_ctrl
  import aes_cfb_pkg::*;
#(
  parameter int ROUND_COUNT = AES_ROUNDS_DEF,
  localparam int ROUND_W    = $clog2(ROUND_COUNT + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [OP_W-1:0]    operation,
  input  wire aes_sts_t           sts,
  output aes_cmd_t                cmd,
  output logic [ROUND_W-1:0]      key_rd_idx
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [ROUND_W-1:0] LAST_RND = ROUND_W'(ROUND_COUNT);

  logic [1:0]         state_r, state_nxt;
  logic [ROUND_W-1:0] rnd_r, rnd_nxt;
  logic               accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    cmd        = '0;
    key_rd_idx = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (operation)
            OP_LOAD_KEY: cmd.key_load = 1'b1;
            OP_ENCRYPT, OP_DECRYPT: begin
              cmd.start   = 1'b1;
              cmd.decrypt = (operation == OP_DECRYPT);
              cmd.key_rd  = 1'b1;
              rnd_nxt     = '0;
              state_nxt   = ST_ROUND;
            end
            default: ;
          endcase
        end
      end
      ST_ROUND: begin
        cmd.init_add   = (rnd_r == '0);
        cmd.round_step = (rnd_r != '0);
        cmd.last_round = (rnd_r == LAST_RND);
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FINISH;
        end else begin
          // prefetch next round's key
          cmd.key_rd = 1'b1;
          key_rd_idx = rnd_r + 1'b1;
          rnd_nxt    = rnd_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.out_busy) else $error("result written over a pending one");

  a_start_then_add: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> cmd.init_add) else $error("initial key add did not follow start");

  a_last_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.last_round |=> state_r == ST_FINISH) else $error("last round not followed by finish");

  a_key_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.init_add || cmd.round_step) |-> $past(cmd.key_rd))
    else $error("round used a key that was not fetched");

endmodule : aes_cfb_ctrl
`default_nettype wire

[hdl/aes_cfb_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// aes_cfb_dp
// Datapath: IV registers, round key store, work state with one shared round
// unit, chaining value and the output register.
// ---------------------------------------------------------------------------
module aes_cfb_dp
  import aes_cfb_pkg::*;
#(
  parameter int ROUND_COUNT = AES_ROUNDS_DEF,
  localparam int ROUND_W    = $clog2(ROUND_COUNT + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [HALF_W-1:0]     cfg_wdata,
  input  wire aes_cmd_t              cmd,
  input  wire logic [ROUND_W-1:0]    key_rd_idx,
  output aes_sts_t                   sts
);

  localparam int KEY_ROWS  = ROUND_COUNT + 1;
  localparam int KEY_SLOTS = 2 * KEY_ROWS;

  logic [SLOT_W-1:0]  key_slot;
  logic [HALF_W-1:0]  key_word;
  logic               restart;
  logic [BLOCK_W-1:0] blk_in;

  assign key_slot = in_tdata[4:0];
  assign key_word = in_tdata[68:5];
  assign restart  = in_tdata[69];
  assign blk_in   = {in_tdata[133:70], in_tdata[197:134]};

  logic [HALF_W-1:0]  iv_high_r, iv_low_r;
  logic [BLOCK_W-1:0] chain_r, state_r, blk_r, res_r;
  logic               dec_r, out_valid_r;

  // round key store, upper and lower halves of each round key
  logic [HALF_W-1:0]  key_hi_mem [KEY_ROWS];
  logic [HALF_W-1:0]  key_lo_mem [KEY_ROWS];
  logic [HALF_W-1:0]  kd_hi_r, kd_lo_r;
  logic [ROUND_W-1:0] wr_row;
  logic               wr_ok;

  assign wr_ok  = (32'(key_slot) < KEY_SLOTS);
  assign wr_row = ROUND_W'(key_slot >> 1);

  always_ff @(posedge clk) begin
    if (cmd.key_load && wr_ok) begin
      if (key_slot[0]) key_lo_mem[wr_row] <= key_word;
      else             key_hi_mem[wr_row] <= key_word;
    end
    if (cmd.key_rd) begin
      kd_hi_r <= key_hi_mem[key_rd_idx];
      kd_lo_r <= key_lo_mem[key_rd_idx];
    end
  end

  // shared round unit
  logic [BLOCK_W-1:0] rkey, ss, mixed, state_nxt, res_nxt, chain_start;

  assign rkey        = {kd_hi_r, kd_lo_r};
  assign ss          = sub_shift(state_r);
  assign mixed       = cmd.last_round ? ss : mix_columns(ss);
  assign chain_start = restart ? {iv_high_r, iv_low_r} : chain_r;
  assign res_nxt     = state_r ^ blk_r;

  always_comb begin
    state_nxt = state_r;
    if (cmd.start)           state_nxt = chain_start;
    else if (cmd.init_add)   state_nxt = state_r ^ rkey;
    else if (cmd.round_step) state_nxt = mixed ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_high_r   <= '0;
      iv_low_r    <= '0;
      chain_r     <= '0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_IV_HIGH: iv_high_r <= cfg_wdata;
          CFG_IV_LOW:  iv_low_r  <= cfg_wdata;
          default: ;
        endcase
      end
      state_r <= state_nxt;
      if (cmd.start) begin
        chain_r <= chain_start;
      end else if (cmd.finish) begin
        chain_r <= dec_r ? blk_r : res_nxt;
      end
      if (cmd.finish)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk_r <= blk_in;
      dec_r <= cmd.decrypt;
    end
    if (cmd.finish) res_r <= res_nxt;
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {res_r[HALF_W-1:0], res_r[BLOCK_W-1:HALF_W]};

endmodule : aes_cfb_dp
`default_nettype wire

[tb/aes128_cfb_cipher_tb.sv]
// ---------------------------------------------------------------------------
// aes128_cfb_cipher_tb
// Self-checking bench for the AES-128 CFB128 core. Requests come from a
// queue and are driven in bursts with random gaps. The output side stalls on
// its own pattern. Each accepted request runs through a local AES model that
// keeps its own key store, chaining value and IV. Each result is checked
// against the oldest expected block. The IV is rewritten between phases,
// only while the core is idle.
// ---------------------------------------------------------------------------
module aes128_cfb_cipher_tb;
  import aes_cfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS         = AES_ROUNDS_DEF;
  localparam int KEY_SLOTS      = 2 * (ROUNDS + 1);
  localparam int SETTLE_CYCLES  = 24;
  localparam int NUM_PHASES     = 5;
  localparam int RAND_PER_PHASE = 120;
  localparam int MAX_SHOWN      = 10;

  // code the core must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] key_slot;
    logic [63:0]       key_word;
    logic              restart;
    logic [63:0]       block_high;
    logic [63:0]       block_low;
    logic              hold_for_drain;
  } cipher_req_t;

  typedef struct {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } cipher_blk_t;

  typedef enum {RX_READY, RX_RANDOM, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = OP_LOAD_KEY;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = CFG_IV_HIGH;
  logic [HALF_W-1:0]     cfg_wdata  = '0;

  aes128_cfb_cipher #(
    .ROUND_COUNT(ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  cipher_req_t  req_q[$];
  cipher_blk_t  expected_blocks[$];
  logic [7:0]   sub_tbl [256];
  logic [63:0]  key_store [KEY_SLOTS];
  logic [127:0] chain_val;
  logic [63:0]  iv_hi, iv_lo;
  int           errors = 0;

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p, x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = mul2(x);
    end
    return p;
  endfunction

  // S-box from the field inverse (x^254, 0 maps to 0) and the affine map
  function automatic logic [7:0] sbox_entry(input logic [7:0] x);
    logic [7:0] inv;
    inv = 8'h01;
    for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
               ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) sub_tbl[i] = sbox_entry(8'(i));
  end

  // forward cipher of the chaining value; byte 0 is the top byte
  function automatic logic [127:0] aes_keystream(input logic [127:0] cv);
    logic [7:0]   st [16];
    logic [7:0]   t [16];
    logic [127:0] rk;
    logic [127:0] packed_st;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) st[i] = cv[127-8*i -: 8];
    for (int rnd = 0; rnd <= ROUNDS; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[c*4+r] = sub_tbl[st[((c + r) % 4) * 4 + r]];
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c];
          a1 = t[4*c+1];
          a2 = t[4*c+2];
          a3 = t[4*c+3];
          if (rnd < ROUNDS) begin
            all       = a0 ^ a1 ^ a2 ^ a3;
            st[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
            st[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
            st[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
            st[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
          end else begin
            st[4*c]   = a0;
            st[4*c+1] = a1;
            st[4*c+2] = a2;
            st[4*c+3] = a3;
          end
        end
      end
      rk = {key_store[2*rnd], key_store[2*rnd+1]};
      for (int i = 0; i < 16; i++) st[i] ^= rk[127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) packed_st[127-8*i -: 8] = st[i];
    return packed_st;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_block();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return rand64();
  endfunction

  function automatic cipher_req_t mk_req(input logic [OP_W-1:0] op,
                                         input logic [SLOT_W-1:0] slot,
                                         input logic [63:0] word,
                                         input logic restart,
                                         input logic [63:0] bh,
                                         input logic [63:0] bl);
    cipher_req_t r;
    r.op             = op;
    r.key_slot       = slot;
    r.key_word       = word;
    r.restart        = restart;
    r.block_high     = bh;
    r.block_low      = bl;
    r.hold_for_drain = 1'b0;
    return r;
  endfunction

  // mostly cipher requests with random content; some key rewrites and noise
  function automatic cipher_req_t rand_req();
    cipher_req_t r;
    logic [OP_W-1:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      op = OP_LOAD_KEY;
    else if (pick < 15) op = OP_UNUSED;
    else if (pick < 58) op = OP_ENCRYPT;
    else                op = OP_DECRYPT;
    r = mk_req(op, SLOT_W'($urandom_range(0, 31)), rand64(),
               $urandom_range(0, 99) < 15, rand_block(), rand_block());
    r.hold_for_drain = ($urandom_range(0, 39) == 0);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
  endtask

  // ---- sender: bursts of requests with random gaps ----
  int          burst_left;
  int          gap_left;
  cipher_req_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left   = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (req_q.size() == 0 ||
                   (req_q[0].hold_for_drain && (in_tvalid || expected_blocks.size() != 0))) begin
        in_tvalid <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.op;
        in_tdata  <= {2'b00, nxt.block_low, nxt.block_high, nxt.restart,
                      nxt.key_word, nxt.key_slot};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
    end
  end

  // ---- receiver stall pattern ----
  rx_mode_e rx_mode;
  int       rx_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_mode    = RX_READY;
      rx_left    = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_READY:  out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:   out_tready <= ~out_tready;
      endcase
    end
  end

  // ---- prediction and checking ----
  logic [127:0] blk, ks, res;
  cipher_blk_t  want;

  always @(posedge clk) begin
    if (!rst_n) begin
      chain_val = '0;
      iv_hi     = '0;
      iv_lo     = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_IV_HIGH)     iv_hi = cfg_wdata;
        else if (cfg_addr == CFG_IV_LOW) iv_lo = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_LOAD_KEY: begin
            if (in_tdata[4:0] < KEY_SLOTS) key_store[in_tdata[4:0]] = in_tdata[68:5];
          end
          OP_ENCRYPT, OP_DECRYPT: begin
            if (in_tdata[69]) chain_val = {iv_hi, iv_lo};
            blk = {in_tdata[133:70], in_tdata[197:134]};
            ks  = aes_keystream(chain_val);
            res = ks ^ blk;
            chain_val = (in_tuser == OP_ENCRYPT) ? res : blk;
            want.result_high = res[127:64];
            want.result_low  = res[63:0];
            expected_blocks.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: result with nothing expected: %h", $realtime, out_tdata);
        end else begin
          want = expected_blocks.pop_front();
          if (out_tdata[63:0] !== want.result_high)
            note_mismatch("result_high", want.result_high, out_tdata[63:0]);
          if (out_tdata[127:64] !== want.result_low)
            note_mismatch("result_low", want.result_low, out_tdata[127:64]);
        end
      end
    end
  end

  // ---- stimulus and end of run ----
  task automatic wait_idle();
    while (req_q.size() != 0 || in_tvalid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_iv(input logic [63:0] hi, input logic [63:0] lo);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_IV_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_addr  <= CFG_IV_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        1:       write_iv('0, '0);
        2:       write_iv('1, '1);
        3:       write_iv('1, '0);
        default: write_iv(rand64(), rand64());
      endcase
      if (ph == 0) begin
        // every key slot written before any cipher request
        for (int s = 0; s < KEY_SLOTS; s++)
          req_q.push_back(mk_req(OP_LOAD_KEY, SLOT_W'(s),
                                 (s == 0) ? '1 : (s == KEY_SLOTS - 1) ? '0 : rand64(),
                                 s[0], rand64(), rand64()));
        // no restart yet: chain starts from zero
        req_q.push_back(mk_req(OP_ENCRYPT, '0, '0, 1'b0, '0, '0));
        // unused code with restart set must not touch the chain
        req_q.push_back(mk_req(OP_UNUSED, '1, '1, 1'b1, '1, '1));
        req_q.push_back(mk_req(OP_ENCRYPT, '1, '1, 1'b0, '1, '1));
        // out-of-range slots are dropped, restart on a load is ignored
        req_q.push_back(mk_req(OP_LOAD_KEY, 5'd31, rand64(), 1'b1, '0, '0));
        req_q.push_back(mk_req(OP_LOAD_KEY, SLOT_W'(KEY_SLOTS), rand64(), 1'b1, '1, '1));
        req_q.push_back(mk_req(OP_DECRYPT, '0, '0, 1'b0, rand64(), rand64()));
        req_q.push_back(mk_req(OP_DECRYPT, '0, '0, 1'b1, '1, '1));
        req_q.push_back(mk_req(OP_ENCRYPT, '0, '0, 1'b1, '0, '0));
      end
      repeat (RAND_PER_PHASE) req_q.push_back(rand_req());
    end
    wait_idle();
    if (expected_blocks.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_blocks.size());
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
